// ===== rtl/core/icmpfr_pkg.sv =====
// Shared types, constants and codes of the ICMP filter receive ring.
package icmpfr_pkg;

  // Sizing of the block
  localparam int unsigned Rules     = 4;
  localparam int unsigned RingDepth = 16;
  localparam int unsigned ByteLimit = 32768;
  localparam int unsigned MaxPacket = 32768;

  // Header length thresholds for the compared fields
  localparam int unsigned HdrCodeMin = 2;
  localparam int unsigned HdrIdMin   = 6;
  localparam int unsigned HdrSeqMin  = 8;

  // Field widths
  localparam int unsigned LenW     = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned ScopeW   = 8;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned IdW      = 16;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned RuleW    = 51;
  localparam int unsigned RuleCntW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RuleW;

  // Ring bookkeeping widths
  localparam int unsigned SlotW  = $clog2(RingDepth);
  localparam int unsigned CountW = $clog2(RingDepth + 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RULE_COUNT = 3'd0,
    REG_RULE_ZERO  = 3'd1,
    REG_RULE_ONE   = 3'd2,
    REG_RULE_TWO   = 3'd3,
    REG_RULE_THREE = 3'd4
  } cfg_reg_e;

  // Command codes
  typedef enum logic {
    CMD_ARRIVE  = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_QUEUED   = 3'd0,
    ST_FILTERED = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_DEQUEUED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  // Filter rule as packed in its register
  typedef struct packed {
    logic            cmp_seq;
    logic            cmp_id;
    logic            cmp_code;
    logic [SeqW-1:0]  seq;
    logic [IdW-1:0]   id;
    logic [CodeW-1:0] code;
    logic [TypeW-1:0] mtype;
  } rule_t;

  // One stored descriptor
  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [AddrW-1:0]  source;
    logic [ScopeW-1:0] scope;
  } entry_t;

  // Registered request beat
  typedef struct packed {
    logic              command;
    logic [LenW-1:0]   pkt_len;
    logic [TypeW-1:0]  msg_type;
    logic [CodeW-1:0]  msg_code;
    logic [IdW-1:0]    msg_id;
    logic [SeqW-1:0]   msg_seq;
    logic [AddrW-1:0]  source_address;
    logic [ScopeW-1:0] arrival_scope;
  } req_t;

  // Registered result beat
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    out_len;
    logic [AddrW-1:0]   out_source;
    logic [ScopeW-1:0]  out_scope;
    logic [LenW-1:0]    queued_bytes;
    logic [CountW-1:0]  queued_count;
  } res_t;

endpackage

// ===== rtl/core/icmpfr_if.sv =====
// Request and result channel interfaces of the ICMP filter receive ring.
interface icmpfr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [icmpfr_pkg::LenW-1:0]   pkt_len;
  logic [icmpfr_pkg::TypeW-1:0]  msg_type;
  logic [icmpfr_pkg::CodeW-1:0]  msg_code;
  logic [icmpfr_pkg::IdW-1:0]    msg_id;
  logic [icmpfr_pkg::SeqW-1:0]   msg_seq;
  logic [icmpfr_pkg::AddrW-1:0]  source_address;
  logic [icmpfr_pkg::ScopeW-1:0] arrival_scope;

  modport source (
    output valid, command, pkt_len, msg_type, msg_code, msg_id, msg_seq,
           source_address, arrival_scope,
    input  ready
  );
  modport sink (
    input  valid, command, pkt_len, msg_type, msg_code, msg_id, msg_seq,
           source_address, arrival_scope,
    output ready
  );
endinterface

interface icmpfr_res_if;
  logic                           valid;
  logic                           ready;
  logic [icmpfr_pkg::StatusW-1:0] status;
  logic [icmpfr_pkg::LenW-1:0]    out_len;
  logic [icmpfr_pkg::AddrW-1:0]   out_source;
  logic [icmpfr_pkg::ScopeW-1:0]  out_scope;
  logic [icmpfr_pkg::LenW-1:0]    queued_bytes;
  logic [icmpfr_pkg::CountW-1:0]  queued_count;

  modport source (
    output valid, status, out_len, out_source, out_scope, queued_bytes, queued_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_len, out_source, out_scope, queued_bytes, queued_count,
    output ready
  );
endinterface

// ===== rtl/core/icmp_filter_receive_ring.sv =====
// Top level of the ICMP filter receive ring: filter, descriptor ring and result register.
//
// Each request beat is either a packet arrival or a dequeue, and gives exactly one result
// beat. Arrivals are checked for length, matched against up to four rules in parallel and
// then admitted into a 16-entry descriptor ring bounded also by 32768 held bytes; a dequeue
// returns the oldest descriptor or an empty status. The block sustains one beat per cycle
// while the result side accepts; a held result stalls the input register. A beat is
// captured in an input register and then resolved into the result register. The user is
// to write rules and the rule count through the configuration port while the block is
// idle; the block itself does not enforce this. No clearing pass runs after reset.
module icmp_filter_receive_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [icmpfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [icmpfr_pkg::CfgDataW-1:0] cfg_data_i,
  icmpfr_req_if.sink                  req_i,
  icmpfr_res_if.source                res_o
);
  import icmpfr_pkg::*;

  // Configuration
  logic [RuleCntW-1:0] rule_count_q;
  rule_t               rules_q [Rules];

  // Input stage
  logic req_valid_q;
  req_t req_q;

  // Result stage
  logic res_valid_q;
  res_t res_q, res_d;

  // Ring state
  entry_t            entry_q [RingDepth];
  logic [SlotW-1:0]  rd_slot_q, rd_slot_d;
  logic [SlotW-1:0]  wr_slot_q, wr_slot_d;
  logic [CountW-1:0] held_q, held_d;
  logic [LenW-1:0]   bytes_q, bytes_d;
  logic              store_en;

  logic advance;

  // Handshake: the input register refills whenever its beat moves on
  assign advance       = req_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready   = !req_valid_q || advance;

  // Hold configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
      for (int i = 0; i < Rules; i++) begin
        rules_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_RULE_COUNT) begin
        rule_count_q <= cfg_data_i[RuleCntW-1:0];
      end
      for (int i = 0; i < Rules; i++) begin
        if (cfg_idx_i == CfgIdxW'(i + 1)) begin
          rules_q[i] <= rule_t'(cfg_data_i);
        end
      end
    end
  end

  // Capture the request beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.command        <= req_i.command;
      req_q.pkt_len        <= req_i.pkt_len;
      req_q.msg_type       <= req_i.msg_type;
      req_q.msg_code       <= req_i.msg_code;
      req_q.msg_id         <= req_i.msg_id;
      req_q.msg_seq        <= req_i.msg_seq;
      req_q.source_address <= req_i.source_address;
      req_q.arrival_scope  <= req_i.arrival_scope;
    end
  end

  // Rule matching, all rules in parallel
  logic [RuleCntW-1:0] active_cnt;
  logic [Rules-1:0]    rule_hit;
  logic                bad_len;
  logic                ring_full;
  logic [LenW:0]       bytes_sum;
  entry_t              head;

  assign active_cnt = (rule_count_q > RuleCntW'(Rules)) ? RuleCntW'(Rules) : rule_count_q;

  always_comb begin
    for (int i = 0; i < Rules; i++) begin
      rule_hit[i] = (RuleCntW'(i) < active_cnt)
                 && (rules_q[i].mtype == req_q.msg_type)
                 && (!rules_q[i].cmp_code
                     || (req_q.pkt_len >= LenW'(HdrCodeMin)
                         && rules_q[i].code == req_q.msg_code))
                 && (!rules_q[i].cmp_id
                     || (req_q.pkt_len >= LenW'(HdrIdMin)
                         && rules_q[i].id == req_q.msg_id))
                 && (!rules_q[i].cmp_seq
                     || (req_q.pkt_len >= LenW'(HdrSeqMin)
                         && rules_q[i].seq == req_q.msg_seq));
    end
  end

  assign bad_len   = (req_q.pkt_len == '0)
                  || ({1'b0, req_q.pkt_len} > (LenW + 1)'(MaxPacket))
                  || ({1'b0, req_q.pkt_len} > (LenW + 1)'(ByteLimit));
  assign bytes_sum = {1'b0, bytes_q} + {1'b0, req_q.pkt_len};
  assign ring_full = (held_q >= CountW'(RingDepth))
                  || (bytes_sum > (LenW + 1)'(ByteLimit));
  assign head      = entry_q[rd_slot_q];

  // Resolve the beat against the ring
  always_comb begin
    rd_slot_d = rd_slot_q;
    wr_slot_d = wr_slot_q;
    held_d    = held_q;
    bytes_d   = bytes_q;
    store_en  = 1'b0;
    res_d     = '0;
    res_d.status = ST_EMPTY;

    if (req_q.command == CMD_ARRIVE) begin
      priority if (bad_len) begin
        res_d.status = ST_BAD_LEN;
      end else if (active_cnt != '0 && rule_hit == '0) begin
        res_d.status = ST_FILTERED;
      end else if (ring_full) begin
        res_d.status = ST_FULL;
      end else begin
        res_d.status = ST_QUEUED;
        store_en     = 1'b1;
        wr_slot_d    = wr_slot_q + 1'b1;
        held_d       = held_q + 1'b1;
        bytes_d      = bytes_sum[LenW-1:0];
      end
    end else if (held_q == '0) begin
      res_d.status = ST_EMPTY;
    end else begin
      res_d.status     = ST_DEQUEUED;
      res_d.out_len    = head.len;
      res_d.out_source = head.source;
      res_d.out_scope  = head.scope;
      rd_slot_d        = rd_slot_q + 1'b1;
      held_d           = held_q - 1'b1;
      bytes_d          = (bytes_q >= head.len) ? (bytes_q - head.len) : '0;
    end

    res_d.queued_bytes = bytes_d;
    res_d.queued_count = held_d;
  end

  // Advance ring pointers and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      wr_slot_q <= '0;
      held_q    <= '0;
      bytes_q   <= '0;
    end else if (advance) begin
      rd_slot_q <= rd_slot_d;
      wr_slot_q <= wr_slot_d;
      held_q    <= held_d;
      bytes_q   <= bytes_d;
    end
  end

  // Store the admitted descriptor
  always_ff @(posedge clk_i) begin
    if (advance && store_en) begin
      entry_q[wr_slot_q] <= '{len:    req_q.pkt_len,
                              source: req_q.source_address,
                              scope:  req_q.arrival_scope};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.out_len      = res_q.out_len;
  assign res_o.out_source   = res_q.out_source;
  assign res_o.out_scope    = res_q.out_scope;
  assign res_o.queued_bytes = res_q.queued_bytes;
  assign res_o.queued_count = res_q.queued_count;

  // Ring never holds more entries or bytes than its bounds
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CountW'(RingDepth))
    else $error("ring entry count above depth");

  a_bytes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, bytes_q} <= (LenW + 1)'(ByteLimit))
    else $error("ring byte total above limit");

  // An empty ring holds no bytes
  a_empty_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == '0 |-> bytes_q == '0)
    else $error("empty ring with bytes held");

  // Write slot leads read slot by the entry count
  a_slot_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_slot_q == SlotW'(rd_slot_q + held_q[SlotW-1:0]))
    else $error("ring pointers disagree with entry count");

endmodule

// ===== verif/tb.sv =====
// Testbench for the ICMP filter receive ring: directed beats, then randomised checked phases.
`timescale 1ns / 1ps

module tb;
  import icmpfr_pkg::*;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseBeats  = 130;
  localparam int unsigned HoldCycles  = 60;

  // One directed beat; the outcome is typed in only where it is obvious
  typedef struct packed {
    logic typed;
    req_t stim;
    res_t want;
  } row_t;

  localparam res_t NoWant = '0;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  icmpfr_req_if req_bus ();
  icmpfr_res_if res_bus ();

  icmp_filter_receive_ring dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  // Mirror of the filter configuration and the descriptor ring
  logic [RuleCntW-1:0] rule_cnt_mirror;
  rule_t               rule_mirror [Rules];
  entry_t              ring_mirror [RingDepth];
  logic [SlotW-1:0]    rd_slot;
  logic [SlotW-1:0]    wr_slot;
  logic [CountW-1:0]   held_n;
  logic [LenW-1:0]     held_b;

  // Outcomes of accepted beats still to come out, oldest first
  res_t outcomes_due [$];

  int mismatches;
  int sink_hold;
  bit idle_on;
  int pop_pct;
  int arrivals_sent;
  int pops_sent;
  int settings_used;
  int status_seen [1 << StatusW];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic req_t beat_of(cmd_e c, logic [LenW-1:0] len, logic [TypeW-1:0] ty,
                                   logic [CodeW-1:0] code, logic [IdW-1:0] id,
                                   logic [SeqW-1:0] seq, logic [AddrW-1:0] src,
                                   logic [ScopeW-1:0] scope);
    req_t q;
    q.command        = c;
    q.pkt_len        = len;
    q.msg_type       = ty;
    q.msg_code       = code;
    q.msg_id         = id;
    q.msg_seq        = seq;
    q.source_address = src;
    q.arrival_scope  = scope;
    return q;
  endfunction

  // Arrival or dequeue beat with every field random
  function automatic req_t rand_fields(cmd_e c);
    return beat_of(c, LenW'($urandom), TypeW'($urandom), CodeW'($urandom), IdW'($urandom),
                   SeqW'($urandom), AddrW'($urandom), ScopeW'($urandom));
  endfunction

  function automatic logic [CfgDataW-1:0] rand_word();
    return CfgDataW'({$urandom, $urandom});
  endfunction

  // A rule hits when the type matches and every flagged field is present and equal
  function automatic bit rule_hit(rule_t r, int unsigned hlen, req_t q);
    if (r.mtype != q.msg_type) return 1'b0;
    if (r.cmp_code && (hlen < HdrCodeMin || r.code != q.msg_code)) return 1'b0;
    if (r.cmp_id && (hlen < HdrIdMin || r.id != q.msg_id)) return 1'b0;
    if (r.cmp_seq && (hlen < HdrSeqMin || r.seq != q.msg_seq)) return 1'b0;
    return 1'b1;
  endfunction

  // Resolve one beat against the mirror and advance it
  function automatic res_t ring_outcome(req_t q);
    res_t        o;
    int unsigned hlen;
    int unsigned active;
    bit          hit;
    o = '0;
    if (q.command == CMD_DEQUEUE) begin
      if (held_n == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.status     = ST_DEQUEUED;
        o.out_len    = ring_mirror[rd_slot].len;
        o.out_source = ring_mirror[rd_slot].source;
        o.out_scope  = ring_mirror[rd_slot].scope;
        held_b  = (held_b >= o.out_len) ? held_b - o.out_len : '0;
        // ring depth is a power of two, so the slot wraps by itself
        rd_slot = rd_slot + 1'b1;
        held_n  = held_n - 1'b1;
      end
    end else if (q.pkt_len == 0 || q.pkt_len > MaxPacket || q.pkt_len > ByteLimit) begin
      o.status = ST_BAD_LEN;
    end else begin
      active = (rule_cnt_mirror > Rules) ? Rules : 32'(rule_cnt_mirror);
      hlen   = (q.pkt_len >= HeaderBytes) ? HeaderBytes : 32'(q.pkt_len);
      hit    = (active == 0);
      for (int k = 0; k < active; k++) begin
        if (rule_hit(rule_mirror[k], hlen, q)) hit = 1'b1;
      end
      if (!hit) begin
        o.status = ST_FILTERED;
      end else if (held_n >= RingDepth || int'(held_b) + int'(q.pkt_len) > ByteLimit) begin
        o.status = ST_FULL;
      end else begin
        o.status                   = ST_QUEUED;
        ring_mirror[wr_slot].len    = q.pkt_len;
        ring_mirror[wr_slot].source = q.source_address;
        ring_mirror[wr_slot].scope  = q.arrival_scope;
        wr_slot = wr_slot + 1'b1;
        held_n  = held_n + 1'b1;
        held_b  = held_b + q.pkt_len;
      end
    end
    o.queued_bytes = held_b;
    o.queued_count = held_n;
    return o;
  endfunction

  // Random beat: mostly headers lifted from the rule registers, some of them spoilt
  function automatic req_t rand_beat();
    req_t        q;
    rule_t       r;
    int unsigned pick;
    q = rand_fields(CMD_ARRIVE);
    if ($urandom_range(99) < pop_pct) q.command = CMD_DEQUEUE;
    pick = $urandom_range(99);
    if (pick < 40) q.pkt_len = LenW'($urandom_range(10, 1));
    else if (pick < 75) q.pkt_len = LenW'($urandom_range(200, 11));
    else if (pick < 85) q.pkt_len = LenW'($urandom_range(MaxPacket, 201));
    else if (pick < 90) begin
      q.pkt_len = $urandom_range(1) ? '0 : LenW'($urandom_range(65535, MaxPacket + 1));
    end
    if ($urandom_range(99) < 70) begin
      r = rule_mirror[$urandom_range(Rules - 1)];
      q.msg_type = r.mtype;
      q.msg_code = r.code;
      q.msg_id   = r.id;
      q.msg_seq  = r.seq;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: q.msg_type = TypeW'($urandom);
          1: q.msg_code = CodeW'($urandom);
          2: q.msg_id   = IdW'($urandom);
          default: q.msg_seq = SeqW'($urandom);
        endcase
      end
    end
    return q;
  endfunction

  // Write one register and keep the mirror in step
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RULE_COUNT: rule_cnt_mirror = data[RuleCntW-1:0];
      REG_RULE_ZERO, REG_RULE_ONE, REG_RULE_TWO, REG_RULE_THREE: begin
        rule_mirror[idx - REG_RULE_ZERO] = rule_t'(data);
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one beat until taken, then record its outcome
  task automatic send_beat(req_t q, logic typed, res_t want);
    res_t calc;
    req_bus.valid          <= 1'b1;
    req_bus.command        <= q.command;
    req_bus.pkt_len        <= q.pkt_len;
    req_bus.msg_type       <= q.msg_type;
    req_bus.msg_code       <= q.msg_code;
    req_bus.msg_id         <= q.msg_id;
    req_bus.msg_seq        <= q.msg_seq;
    req_bus.source_address <= q.source_address;
    req_bus.arrival_scope  <= q.arrival_scope;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    calc = ring_outcome(q);
    outcomes_due.push_back(typed ? want : calc);
    if (q.command == CMD_DEQUEUE) pops_sent++;
    else arrivals_sent++;
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    int n;
    if (!idle_on || $urandom_range(3) != 0) return;
    n = $urandom_range(7, 1);
    req_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every outcome has come out and the pipeline is quiet
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (outcomes_due.size() == 0) begin
      $error("result beat with no outcome pending");
      mismatches++;
      return;
    end
    want = outcomes_due.pop_front();
    status_seen[want.status]++;
    check_field("status", 32'(want.status), 32'(res_bus.status));
    check_field("out_len", 32'(want.out_len), 32'(res_bus.out_len));
    check_field("out_source", want.out_source, res_bus.out_source);
    check_field("out_scope", 32'(want.out_scope), 32'(res_bus.out_scope));
    check_field("queued_bytes", 32'(want.queued_bytes), 32'(res_bus.queued_bytes));
    check_field("queued_count", 32'(want.queued_count), 32'(res_bus.queued_count));
  endtask

  // Result side: check every beat taken, stall in bursts or on a long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) check_result();
      if (sink_hold > 0) begin
        sink_hold--;
        res_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(7, 1) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", QuietLimit);
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    row_t        open_rows [11];
    row_t        rule_rows [12];
    int unsigned cnt;

    rst_n = 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    req_bus.valid          <= 1'b0;
    req_bus.command        <= CMD_ARRIVE;
    req_bus.pkt_len        <= '0;
    req_bus.msg_type       <= '0;
    req_bus.msg_code       <= '0;
    req_bus.msg_id         <= '0;
    req_bus.msg_seq        <= '0;
    req_bus.source_address <= '0;
    req_bus.arrival_scope  <= '0;
    rule_cnt_mirror = '0;
    foreach (rule_mirror[k]) rule_mirror[k] = '0;
    rd_slot = '0;
    wr_slot = '0;
    held_n  = '0;
    held_b  = '0;
    mismatches    = 0;
    sink_hold     = 0;
    idle_on       = 1'b1;
    pop_pct       = 30;
    arrivals_sent = 0;
    pops_sent     = 0;
    settings_used = 1;
    foreach (status_seen[k]) status_seen[k] = 0;

    // No rules: lengths, byte bound and dequeue edges
    open_rows = '{
      '{1'b1, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0),
        '{ST_EMPTY, 16'd0, 32'd0, 8'd0, 16'd0, 5'd0}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'd0, 8'd8, '0, '0, '0, 32'h1, 8'd1),
        '{ST_BAD_LEN, 16'd0, 32'd0, 8'd0, 16'd0, 5'd0}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'd32769, 8'd8, '0, '0, '0, 32'h2, 8'd2),
        '{ST_BAD_LEN, 16'd0, 32'd0, 8'd0, 16'd0, 5'd0}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                      32'hFFFF_FFFF, 8'hFF),
        '{ST_BAD_LEN, 16'd0, 32'd0, 8'd0, 16'd0, 5'd0}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'd1, '0, '0, '0, '0, 32'hFFFF_FFFF, 8'hFF),
        '{ST_QUEUED, 16'd0, 32'd0, 8'd0, 16'd1, 5'd1}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'd32767, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, '0, '0),
        '{ST_QUEUED, 16'd0, 32'd0, 8'd0, 16'd32768, 5'd2}},
      '{1'b1, beat_of(CMD_ARRIVE, 16'd1, 8'd0, '0, '0, '0, 32'h3, 8'd3),
        '{ST_FULL, 16'd0, 32'd0, 8'd0, 16'd32768, 5'd2}},
      '{1'b1, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0),
        '{ST_DEQUEUED, 16'd1, 32'hFFFF_FFFF, 8'hFF, 16'd32767, 5'd1}},
      '{1'b0, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0), NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd32768, 8'h55, 8'hAA, 16'h5A5A, 16'hA5A5,
                      32'h8000_0001, 8'h80), NoWant},
      '{1'b0, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0), NoWant}
    };

    // Four rules, count above the rule total; short headers and flagged fields
    rule_rows = '{
      '{1'b1, beat_of(CMD_ARRIVE, 16'd1, 8'd8, 8'd0, '0, '0, 32'h0A00_0001, 8'd1),
        '{ST_FILTERED, 16'd0, 32'd0, 8'd0, 16'd0, 5'd0}},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd2, 8'd8, 8'd0, '0, '0, 32'h0A00_0002, 8'd2), NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd100, 8'd8, 8'd1, '0, '0, 32'h0A00_0003, 8'd3), NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd5, 8'd0, '0, 16'hABCD, '0, 32'h0A00_0004, 8'd4),
        NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd6, 8'd0, '0, 16'hABCD, '0, 32'h0A00_0005, 8'd5),
        NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd7, 8'hFF, '0, '0, 16'hFFFF, 32'h0A00_0006, 8'd6),
        NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd8, 8'hFF, '0, '0, 16'hFFFF, 32'h0A00_0007, 8'd7),
        NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd64, 8'd3, 8'h55, 16'h1234, 16'h5678,
                      32'h0A00_0008, 8'd8), NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd64, 8'd3, 8'h55, 16'h1234, 16'h5679,
                      32'h0A00_0009, 8'd9), NoWant},
      '{1'b0, beat_of(CMD_ARRIVE, 16'd20, 8'd9, '0, '0, '0, 32'h0A00_000A, 8'd10), NoWant},
      '{1'b0, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0), NoWant},
      '{1'b0, beat_of(CMD_DEQUEUE, '0, '0, '0, '0, '0, '0, '0), NoWant}
    };

    // Reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (open_rows[k]) begin
      send_beat(open_rows[k].stim, open_rows[k].typed, open_rows[k].want);
      sender_gap();
    end
    drain();

    write_reg(REG_RULE_COUNT, CfgDataW'((1 << RuleCntW) - 1));
    write_reg(REG_RULE_ZERO, rule_t'{cmp_seq: 1'b0, cmp_id: 1'b0, cmp_code: 1'b1,
                                     seq: '0, id: '0, code: 8'h00, mtype: 8'd8});
    write_reg(REG_RULE_ONE, rule_t'{cmp_seq: 1'b0, cmp_id: 1'b1, cmp_code: 1'b0,
                                    seq: '0, id: 16'hABCD, code: '0, mtype: 8'd0});
    write_reg(REG_RULE_TWO, rule_t'{cmp_seq: 1'b1, cmp_id: 1'b0, cmp_code: 1'b0,
                                    seq: 16'hFFFF, id: '0, code: '0, mtype: 8'hFF});
    write_reg(REG_RULE_THREE, rule_t'{cmp_seq: 1'b1, cmp_id: 1'b1, cmp_code: 1'b1,
                                      seq: 16'h5678, id: 16'h1234, code: 8'h55,
                                      mtype: 8'd3});
    settings_used++;
    foreach (rule_rows[k]) begin
      send_beat(rule_rows[k].stim, rule_rows[k].typed, rule_rows[k].want);
      sender_gap();
    end
    drain();

    // Back-pressure: hold the result side while arrivals pile up past the ring depth
    write_reg(REG_RULE_COUNT, '0);
    settings_used++;
    sink_hold = HoldCycles;
    repeat (24) begin
      req_t q;
      q = rand_fields(CMD_ARRIVE);
      q.pkt_len = LenW'($urandom_range(64, 1));
      send_beat(q, 1'b0, NoWant);
    end
    repeat (20) begin
      send_beat(rand_fields(CMD_DEQUEUE), 1'b0, NoWant);
    end
    drain();

    // Random phases, each under a fresh rule setting; the last one without idling
    for (int ph = 0; ph < PhaseCount; ph++) begin
      idle_on = (ph != PhaseCount - 1);
      case (ph)
        0: cnt = 0;
        1: cnt = Rules;
        2: cnt = (1 << RuleCntW) - 1;
        default: cnt = $urandom_range((1 << RuleCntW) - 1);
      endcase
      write_reg(REG_RULE_COUNT, CfgDataW'(cnt) | (rand_word() & ~CfgDataW'((1 << RuleCntW) - 1)));
      for (int k = 0; k < Rules; k++) write_reg(CfgIdxW'(int'(REG_RULE_ZERO) + k), rand_word());
      if (ph == 0) begin
        // writes to indexes past the register list must be ignored
        for (int k = int'(REG_RULE_THREE) + 1; k < (1 << CfgIdxW); k++) begin
          write_reg(CfgIdxW'(k), rand_word());
        end
      end
      settings_used++;
      pop_pct = (ph % 3 == 0) ? 20 : (ph % 3 == 1) ? 40 : 55;
      repeat (PhaseBeats) begin
        send_beat(rand_beat(), 1'b0, NoWant);
        sender_gap();
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("covered %0d arrivals and %0d dequeues over %0d rule settings",
             arrivals_sent, pops_sent, settings_used);
    $display("outcomes: queued %0d filtered %0d full %0d bad length %0d dequeued %0d empty %0d",
             status_seen[ST_QUEUED], status_seen[ST_FILTERED], status_seen[ST_FULL],
             status_seen[ST_BAD_LEN], status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== icmp_filter_receive_ring.f =====
rtl/core/icmpfr_pkg.sv
rtl/core/icmpfr_if.sv
rtl/core/icmp_filter_receive_ring.sv
verif/tb.sv
